FILE: hdl/smcp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// smcp_pkg
// Shared types and character codes for the serial motion command parser.
// ----------------------------------------------------------------------------
package smcp_pkg;

    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_X_UP  = 8'h58;
    localparam logic [7:0] CH_X_LO  = 8'h78;
    localparam logic [7:0] CH_Y_UP  = 8'h59;
    localparam logic [7:0] CH_Y_LO  = 8'h79;
    localparam logic [7:0] CH_M_UP  = 8'h4D;
    localparam logic [7:0] CH_M_LO  = 8'h6D;
    localparam logic [7:0] CH_H_UP  = 8'h48;
    localparam logic [7:0] CH_H_LO  = 8'h68;

    localparam logic [1:0] KIND_STEPPER = 2'd0;
    localparam logic [1:0] KIND_SERVO   = 2'd1;
    localparam logic [1:0] KIND_CORE    = 2'd2;
    localparam logic [1:0] KIND_HELP    = 2'd3;

    // attribute fields on the result beat; count wide enough for up to 15 pushes
    localparam int OUT_ATTRS = 4;
    localparam int CNT_W     = 4;

    typedef logic [31:0] word_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_EVAL,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic start;
        logic eval;
    } walk_ctl_t;

    typedef struct packed {
        logic       hit;
        logic [1:0] kind;
    } walk_res_t;

endpackage
`default_nettype wire

FILE: hdl/smcp_seg_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// smcp_seg_ram
// Segment byte store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module smcp_seg_ram #(
    parameter int DEPTH = 128,
    parameter int AW    = 7
) (
    input  wire logic          clk,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [7:0]    wr_data,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output      logic [7:0]    rd_data
);

    logic [7:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

FILE: hdl/smcp_walk.sv
`default_nettype none
// ----------------------------------------------------------------------------
// smcp_walk
// Backward segment walker: digit accumulator, attribute stack and letter
// decode, plus formatting of the result fields.
// ----------------------------------------------------------------------------
module smcp_walk #(
    parameter int MAX_ATTRS = 4
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire smcp_pkg::walk_ctl_t   ctl,
    input  wire logic [7:0]            data,
    output      smcp_pkg::walk_res_t   res,
    output      smcp_pkg::word_t       value,
    output      logic [2:0]            count,
    output      smcp_pkg::word_t       attr_a,
    output      smcp_pkg::word_t       attr_b,
    output      smcp_pkg::word_t       attr_c,
    output      smcp_pkg::word_t       attr_d
);

    import smcp_pkg::*;

    word_t            value_reg;
    word_t            weight_reg;
    logic [CNT_W-1:0] count_reg;
    word_t            attrs_reg [OUT_ATTRS];
    logic [1:0]       kind_reg;

    logic       is_digit;
    logic       is_push;
    logic       hit;
    logic [1:0] hit_kind;
    logic [3:0] digit;
    word_t      product;

    assign is_digit = (data >= CH_0) && (data <= CH_9);
    assign is_push  = (data == CH_SEMI) || (data == CH_EQ);
    assign digit    = 4'(data - CH_0);
    assign product  = weight_reg * word_t'(digit);

    always_comb
    begin
        hit      = 1'b1;
        hit_kind = KIND_STEPPER;
        case (data) inside
            CH_X_UP, CH_X_LO: hit_kind = KIND_STEPPER;
            CH_Y_UP, CH_Y_LO: hit_kind = KIND_SERVO;
            CH_M_UP, CH_M_LO: hit_kind = KIND_CORE;
            CH_H_UP, CH_H_LO: hit_kind = KIND_HELP;
            default:          hit      = 1'b0;
        endcase
    end

    assign res.hit  = hit;
    assign res.kind = kind_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (ctl.start)
        begin
            count_reg <= '0;
        end
        else if (ctl.eval && is_push && (count_reg < CNT_W'(MAX_ATTRS)))
        begin
            count_reg <= count_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            value_reg  <= '0;
            weight_reg <= 32'd1;
            for (int k = 0; k < OUT_ATTRS; k++)
            begin
                attrs_reg[k] <= '0;
            end
        end
        else if (ctl.eval)
        begin
            if (is_digit)
            begin
                value_reg  <= value_reg + product;
                weight_reg <= (weight_reg << 3) + (weight_reg << 1);
            end
            else if (is_push)
            begin
                if ((count_reg < CNT_W'(MAX_ATTRS)) && (count_reg < CNT_W'(OUT_ATTRS)))
                begin
                    attrs_reg[count_reg[1:0]] <= value_reg;
                end
                value_reg  <= '0;
                weight_reg <= 32'd1;
            end
            if (hit)
            begin
                kind_reg <= hit_kind;
            end
        end
    end

    always_comb
    begin
        value  = '0;
        count  = '0;
        attr_a = '0;
        attr_b = '0;
        attr_c = '0;
        attr_d = '0;
        case (kind_reg)
            KIND_STEPPER, KIND_SERVO:
            begin
                value = value_reg;
            end
            KIND_CORE:
            begin
                value  = value_reg;
                count  = count_reg[2:0];
                attr_a = (count_reg == '0) ? value_reg : attrs_reg[0];
                attr_b = attrs_reg[1];
                attr_c = attrs_reg[2];
                attr_d = attrs_reg[3];
            end
            default:
            begin
                value = '0;
            end
        endcase
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_ATTRS))
        else $error("attribute count beyond limit");

endmodule
`default_nettype wire

FILE: hdl/serial_motion_command_parser_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// serial_motion_command_parser_unit
// Line buffer and '!' command parser for received serial bytes.
// ----------------------------------------------------------------------------
// Ordinary bytes and line feeds: accepted while idle, no result beat. '!' over
// a segment walks its bytes from the last back, each in a read then an evaluate
// state, until a command letter is found; the result beat is then loaded once
// no earlier beat waits on cmd_stall. Input is stalled for all of that.
// A loaded beat waits in the output register while new bytes are taken.
// Reset clears line and segment lengths and the result valid, not the store.
// ----------------------------------------------------------------------------
module serial_motion_command_parser_unit #(
    parameter int LINE_DEPTH = 128,
    parameter int MAX_ATTRS  = 4
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        rx_valid,
    output      logic        rx_stall,
    input  wire logic [7:0]  rx_byte,
    output      logic        cmd_valid,
    input  wire logic        cmd_stall,
    output      logic [1:0]  command_kind,
    output      logic [31:0] command_value,
    output      logic [2:0]  attribute_count,
    output      logic [31:0] attribute_a,
    output      logic [31:0] attribute_b,
    output      logic [31:0] attribute_c,
    output      logic [31:0] attribute_d
);

    import smcp_pkg::*;

    localparam int AW = $clog2(LINE_DEPTH);
    localparam int CW = $clog2(LINE_DEPTH + 1);

    state_t          state_reg, state_next;
    logic [CW-1:0]   line_len_reg, line_len_next;
    logic [CW-1:0]   seg_len_reg, seg_len_next;
    logic [CW-1:0]   idx_reg, idx_next;
    logic            cmd_valid_reg, cmd_valid_next;
    logic            load_out;

    logic [1:0]      command_kind_reg;
    word_t           command_value_reg;
    logic [2:0]      attribute_count_reg;
    word_t           attribute_a_reg;
    word_t           attribute_b_reg;
    word_t           attribute_c_reg;
    word_t           attribute_d_reg;

    logic            rx_accept;
    logic            wr_en;
    logic            rd_en;
    logic [7:0]      rd_data;
    logic [CW-1:0]   idx_dec;

    walk_ctl_t       wctl;
    walk_res_t       wres;
    word_t           w_value;
    logic [2:0]      w_count;
    word_t           w_a, w_b, w_c, w_d;

    assign rx_stall  = (state_reg != S_IDLE);
    assign rx_accept = rx_valid && !rx_stall;
    assign idx_dec   = idx_reg - 1'b1;

    smcp_seg_ram #(
        .DEPTH (LINE_DEPTH),
        .AW    (AW)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (seg_len_reg[AW-1:0]),
        .wr_data (rx_byte),
        .rd_en   (rd_en),
        .rd_addr (idx_dec[AW-1:0]),
        .rd_data (rd_data)
    );

    smcp_walk #(
        .MAX_ATTRS (MAX_ATTRS)
    ) u_walk (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (wctl),
        .data   (rd_data),
        .res    (wres),
        .value  (w_value),
        .count  (w_count),
        .attr_a (w_a),
        .attr_b (w_b),
        .attr_c (w_c),
        .attr_d (w_d)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            line_len_reg  <= '0;
            seg_len_reg   <= '0;
            idx_reg       <= '0;
            cmd_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            line_len_reg  <= line_len_next;
            seg_len_reg   <= seg_len_next;
            idx_reg       <= idx_next;
            cmd_valid_reg <= cmd_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        line_len_next  = line_len_reg;
        seg_len_next   = seg_len_reg;
        idx_next       = idx_reg;
        cmd_valid_next = cmd_valid_reg && cmd_stall;
        wr_en          = 1'b0;
        rd_en          = 1'b0;
        load_out       = 1'b0;
        wctl           = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (rx_accept)
                begin
                    if (rx_byte == CH_LF)
                    begin
                        line_len_next = '0;
                        seg_len_next  = '0;
                    end
                    else if (line_len_reg < CW'(LINE_DEPTH))
                    begin
                        line_len_next = line_len_reg + 1'b1;
                        if (rx_byte == CH_BANG)
                        begin
                            seg_len_next = '0;
                            if (seg_len_reg != '0)
                            begin
                                idx_next   = seg_len_reg;
                                wctl.start = 1'b1;
                                state_next = S_READ;
                            end
                        end
                        else if (seg_len_reg < CW'(LINE_DEPTH))
                        begin
                            wr_en        = 1'b1;
                            seg_len_next = seg_len_reg + 1'b1;
                        end
                    end
                end
            end
            S_READ:
            begin
                rd_en      = 1'b1;
                idx_next   = idx_dec;
                state_next = S_EVAL;
            end
            S_EVAL:
            begin
                wctl.eval = 1'b1;
                if (wres.hit)
                begin
                    state_next = S_EMIT;
                end
                else if (idx_reg == '0)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_READ;
                end
            end
            S_EMIT:
            begin
                if (!cmd_valid_reg || !cmd_stall)
                begin
                    load_out       = 1'b1;
                    cmd_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            command_kind_reg    <= wres.kind;
            command_value_reg   <= w_value;
            attribute_count_reg <= w_count;
            attribute_a_reg     <= w_a;
            attribute_b_reg     <= w_b;
            attribute_c_reg     <= w_c;
            attribute_d_reg     <= w_d;
        end
    end

    assign cmd_valid       = cmd_valid_reg;
    assign command_kind    = command_kind_reg;
    assign command_value   = command_value_reg;
    assign attribute_count = attribute_count_reg;
    assign attribute_a     = attribute_a_reg;
    assign attribute_b     = attribute_b_reg;
    assign attribute_c     = attribute_c_reg;
    assign attribute_d     = attribute_d_reg;

    a_seg_within_line: assert property (@(posedge clk) disable iff (!rst_n)
        seg_len_reg <= line_len_reg)
        else $error("segment longer than line");

    a_lf_clears: assert property (@(posedge clk) disable iff (!rst_n)
        rx_accept && (rx_byte == CH_LF) |=> (line_len_reg == '0) && (seg_len_reg == '0))
        else $error("line feed did not clear lengths");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |-> !(cmd_valid_reg && cmd_stall))
        else $error("result loaded over a waiting beat");

    a_walk_index: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ) |-> (idx_reg != '0) && (idx_reg <= CW'(LINE_DEPTH)))
        else $error("walk index out of range");

endmodule
`default_nettype wire

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the serial motion command parser. A table of
// directed lines runs first, then random command lines, noise and over-long
// lines. Every accepted byte goes through a local line parser, and each
// result beat is checked field by field against the oldest queued command.
// Both channels idle and stall at random, with one calm stretch.
// ----------------------------------------------------------------------------
module testbench;
    import smcp_pkg::*;

    localparam int LINE_DEPTH = 128;
    localparam int MAX_ATTRS  = 4;
    localparam int DIR_ROWS   = 21;
    localparam int RAND_BEATS = 320;
    localparam int DRAIN_CYC  = 2 * LINE_DEPTH + 40;

    typedef struct packed {
        logic [1:0] kind;
        word_t      value;
        logic [2:0] count;
        word_t      attr_a;
        word_t      attr_b;
        word_t      attr_c;
        word_t      attr_d;
    } cmd_t;

    typedef enum logic [1:0] {
        ROW_PREDICT,
        ROW_NONE,
        ROW_RESULT
    } row_mark_t;

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        rx_valid  = 1'b0;
    logic        rx_stall;
    logic [7:0]  rx_byte   = 8'h00;
    logic        cmd_valid;
    logic        cmd_stall = 1'b0;
    logic [1:0]  command_kind;
    logic [31:0] command_value;
    logic [2:0]  attribute_count;
    logic [31:0] attribute_a;
    logic [31:0] attribute_b;
    logic [31:0] attribute_c;
    logic [31:0] attribute_d;

    // local copy of the parser state
    logic [7:0]  seg_buf [LINE_DEPTH];
    int unsigned seg_len  = 0;
    int unsigned line_len = 0;

    cmd_t        pending_cmds [$];
    int unsigned mismatch_count = 0;
    int unsigned rx_beats = 0;
    bit          calm = 1'b0;

    string       dir_text [DIR_ROWS];
    row_mark_t   dir_mark [DIR_ROWS];
    cmd_t        dir_want [DIR_ROWS];

    logic [7:0]  letters [8] = '{CH_X_UP, CH_X_LO, CH_Y_UP, CH_Y_LO,
                                 CH_M_UP, CH_M_LO, CH_H_UP, CH_H_LO};

    serial_motion_command_parser_unit #(
        .LINE_DEPTH (LINE_DEPTH),
        .MAX_ATTRS  (MAX_ATTRS)
    ) u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .rx_valid        (rx_valid),
        .rx_stall        (rx_stall),
        .rx_byte         (rx_byte),
        .cmd_valid       (cmd_valid),
        .cmd_stall       (cmd_stall),
        .command_kind    (command_kind),
        .command_value   (command_value),
        .attribute_count (attribute_count),
        .attribute_a     (attribute_a),
        .attribute_b     (attribute_b),
        .attribute_c     (attribute_c),
        .attribute_d     (attribute_d)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic bit idle_roll();
        return !calm && ($urandom_range(0, 99) < 28);
    endfunction

    function automatic cmd_t mk_cmd(input logic [1:0] k, input word_t v,
                                    input logic [2:0] n, input word_t a);
        cmd_t c;
        c        = '0;
        c.kind   = k;
        c.value  = v;
        c.count  = n;
        c.attr_a = a;
        return c;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH %s: got %0h want %0h at %0t", what, got, want, $realtime);
        mismatch_count++;
    endtask

    // one accepted byte through the line parser
    task automatic parse_rx_byte(input logic [7:0] b, output bit hit, output cmd_t res);
        word_t       value;
        word_t       weight;
        word_t       attrs [MAX_ATTRS];
        int unsigned count;
        int unsigned i;
        logic [7:0]  c;
        hit = 1'b0;
        res = '0;
        if (b == CH_LF)
        begin
            line_len = 0;
            seg_len  = 0;
        end
        else if (line_len < LINE_DEPTH)
        begin
            line_len++;
            if (b == CH_BANG)
            begin
                value  = '0;
                weight = 32'd1;
                count  = 0;
                foreach (attrs[k])
                    attrs[k] = '0;
                i = seg_len;
                while (i > 0 && !hit)
                begin
                    i--;
                    c = seg_buf[i];
                    if (c >= CH_0 && c <= CH_9)
                    begin
                        value  += weight * word_t'(c - CH_0);
                        weight *= 32'd10;
                    end
                    else if (c == CH_SEMI || c == CH_EQ)
                    begin
                        if (count < MAX_ATTRS)
                        begin
                            attrs[count] = value;
                            count++;
                        end
                        value  = '0;
                        weight = 32'd1;
                    end
                    else if (c == CH_X_UP || c == CH_X_LO)
                    begin
                        hit       = 1'b1;
                        res.kind  = KIND_STEPPER;
                        res.value = value;
                    end
                    else if (c == CH_Y_UP || c == CH_Y_LO)
                    begin
                        hit       = 1'b1;
                        res.kind  = KIND_SERVO;
                        res.value = value;
                    end
                    else if (c == CH_M_UP || c == CH_M_LO)
                    begin
                        if (count == 0)
                            attrs[0] = value;
                        hit        = 1'b1;
                        res.kind   = KIND_CORE;
                        res.value  = value;
                        res.count  = count[2:0];
                        res.attr_a = attrs[0];
                        res.attr_b = attrs[1];
                        res.attr_c = attrs[2];
                        res.attr_d = attrs[3];
                    end
                    else if (c == CH_H_UP || c == CH_H_LO)
                    begin
                        hit      = 1'b1;
                        res.kind = KIND_HELP;
                    end
                end
                seg_len = 0;
            end
            else if (seg_len < LINE_DEPTH)
            begin
                seg_buf[seg_len] = b;
                seg_len++;
            end
        end
    endtask

    // typed rows queue their own result, so the parser only tracks state
    task automatic send_byte(input logic [7:0] b, input bit typed);
        bit   hit;
        cmd_t res;
        while (idle_roll())
        begin
            rx_valid <= 1'b0;
            @(posedge clk);
        end
        rx_valid <= 1'b1;
        rx_byte  <= b;
        do
            @(posedge clk);
        while (rx_stall);
        rx_beats++;
        parse_rx_byte(b, hit, res);
        if (hit && !typed)
            pending_cmds.push_back(res);
    endtask

    task automatic send_text(input string s, input bit typed);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], typed);
    endtask

    task automatic send_digits(input int n);
        repeat (n)
            send_byte(8'(CH_0 + $urandom_range(0, 9)), 1'b0);
    endtask

    always @(posedge clk)
    begin : result_check
        cmd_t want;
        if (rst_n && cmd_valid && !cmd_stall)
        begin
            if (pending_cmds.size() == 0)
                report_mismatch("beat with nothing expected", command_value, 32'd0);
            else
            begin
                want = pending_cmds.pop_front();
                if (command_kind !== want.kind)
                    report_mismatch("command_kind", 32'(command_kind), 32'(want.kind));
                if (command_value !== want.value)
                    report_mismatch("command_value", command_value, want.value);
                if (attribute_count !== want.count)
                    report_mismatch("attribute_count", 32'(attribute_count),
                                    32'(want.count));
                if (attribute_a !== want.attr_a)
                    report_mismatch("attribute_a", attribute_a, want.attr_a);
                if (attribute_b !== want.attr_b)
                    report_mismatch("attribute_b", attribute_b, want.attr_b);
                if (attribute_c !== want.attr_c)
                    report_mismatch("attribute_c", attribute_c, want.attr_c);
                if (attribute_d !== want.attr_d)
                    report_mismatch("attribute_d", attribute_d, want.attr_d);
            end
        end
        cmd_stall <= idle_roll();
    end

    initial
    begin : stimulus
        string       long_run;
        int unsigned rand_start;
        int unsigned r;
        int unsigned n;
        logic [7:0]  letter;

        long_run = "";
        repeat (130)
            long_run = {long_run, "7"};

        dir_text = '{"x!", "X4294967295!", "Y4294967296!", "y0000000000007!", "H!",
                     "h99;12!", "M7!", "m12=34;56!", "M1;2;3;4;5;6;7!", "123;45=6!",
                     "!", "X1a\2772!", "M3X5!", "X5!7!", "\n", "Y12\n!",
                     {"X", long_run, "!"}, "\nX9!", {"M", long_run.substr(0, 119), ";5!"},
                     "\nM0=4294967295;!", "\n"};
        dir_mark = '{ROW_RESULT, ROW_RESULT, ROW_RESULT, ROW_RESULT, ROW_RESULT,
                     ROW_RESULT, ROW_RESULT, ROW_PREDICT, ROW_PREDICT, ROW_NONE,
                     ROW_NONE, ROW_PREDICT, ROW_PREDICT, ROW_PREDICT, ROW_NONE,
                     ROW_PREDICT, ROW_PREDICT, ROW_PREDICT, ROW_PREDICT,
                     ROW_PREDICT, ROW_NONE};
        foreach (dir_want[k])
            dir_want[k] = '0;
        dir_want[0] = mk_cmd(KIND_STEPPER, 32'd0, 3'd0, 32'd0);
        dir_want[1] = mk_cmd(KIND_STEPPER, 32'hFFFF_FFFF, 3'd0, 32'd0);
        dir_want[2] = mk_cmd(KIND_SERVO, 32'd0, 3'd0, 32'd0);
        dir_want[3] = mk_cmd(KIND_SERVO, 32'd7, 3'd0, 32'd0);
        dir_want[4] = mk_cmd(KIND_HELP, 32'd0, 3'd0, 32'd0);
        dir_want[5] = mk_cmd(KIND_HELP, 32'd0, 3'd0, 32'd0);
        dir_want[6] = mk_cmd(KIND_CORE, 32'd7, 3'd0, 32'd7);

        repeat (6)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int row = 0; row < DIR_ROWS; row++)
        begin
            send_text(dir_text[row], dir_mark[row] != ROW_PREDICT);
            if (dir_mark[row] == ROW_RESULT)
                pending_cmds.push_back(dir_want[row]);
        end

        rand_start = rx_beats;
        while (rx_beats - rand_start < RAND_BEATS)
        begin
            calm = (rx_beats - rand_start >= 100) && (rx_beats - rand_start < 220);
            r = $urandom_range(0, 99);
            if (r < 72)
            begin
                if ($urandom_range(0, 4) == 0)
                    send_digits($urandom_range(1, 3));
                letter = letters[$urandom_range(0, 7)];
                send_byte(letter, 1'b0);
                if ($urandom_range(0, 9) == 0)
                    send_byte(8'($urandom_range(0, 255)), 1'b0);
                send_digits($urandom_range(0, 3) == 0 ? $urandom_range(0, 12)
                                                      : $urandom_range(1, 5));
                if (letter == CH_M_UP || letter == CH_M_LO)
                begin
                    n = $urandom_range(0, 6);
                    repeat (n)
                    begin
                        send_byte($urandom_range(0, 1) ? CH_SEMI : CH_EQ, 1'b0);
                        send_digits($urandom_range(0, 3) == 0 ? $urandom_range(0, 11)
                                                              : $urandom_range(1, 4));
                    end
                end
                send_byte(CH_BANG, 1'b0);
                if ($urandom_range(0, 9) < 4)
                    send_byte(CH_LF, 1'b0);
            end
            else if (r < 94)
            begin
                repeat ($urandom_range(1, 10))
                    send_byte(8'($urandom_range(0, 255)), 1'b0);
                if ($urandom_range(0, 1))
                    send_byte(CH_BANG, 1'b0);
            end
            else if (r < 97)
            begin
                if ($urandom_range(0, 1))
                begin
                    send_byte(letters[$urandom_range(0, 7)], 1'b0);
                    send_digits($urandom_range(1, 6));
                    send_byte(CH_LF, 1'b0);
                end
                else
                begin
                    send_digits($urandom_range(1, 6));
                    send_byte(CH_BANG, 1'b0);
                end
            end
            else
            begin
                repeat ($urandom_range(124, 134))
                begin
                    if ($urandom_range(0, 3) == 0)
                        send_byte(letters[$urandom_range(0, 7)], 1'b0);
                    else
                        send_byte(8'(CH_0 + $urandom_range(0, 9)), 1'b0);
                end
                send_byte(CH_BANG, 1'b0);
                send_byte(CH_LF, 1'b0);
            end
        end
        calm = 1'b0;
        rx_valid <= 1'b0;

        n = 0;
        while (pending_cmds.size() != 0 && n < 20000)
        begin
            @(posedge clk);
            n++;
        end
        repeat (DRAIN_CYC)
            @(posedge clk);
        if (pending_cmds.size() != 0)
            report_mismatch("commands still expected", 32'(pending_cmds.size()), 32'd0);

        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

FILE: files.f
hdl/smcp_pkg.sv
hdl/smcp_seg_ram.sv
hdl/smcp_walk.sv
hdl/serial_motion_command_parser_unit.sv
tb/sv/testbench.sv
